FILE: rtl/core/pcg32_random_generator_core_defines.svh
// Assertion macros for the checker of the PCG32 generator core.
`ifndef PCG32_RANDOM_GENERATOR_CORE_DEFINES_SVH
`define PCG32_RANDOM_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define PCG32_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcg32 checker: property failed");

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define PCG32_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcg32 checker: property failed");

`endif

FILE: rtl/core/pcg32_pkg.sv
// Types, constants and helper functions of the PCG32 generator core.
`default_nettype none

package pcg32_pkg;

    localparam int STATE_W = 64;
    localparam int WORD_W  = 32;
    localparam int FRAC_W  = 23;
    localparam int HALF_W  = 32;

    localparam logic [STATE_W-1:0] STATE_RESET  = 64'h853C_49E6_748F_EA9B;
    localparam logic [STATE_W-1:0] MULT_RESET   = 64'd6364136223846793005;
    localparam logic [STATE_W-1:0] INCR_RESET   = 64'd1442695040888963407;
    localparam logic [STATE_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [STATE_W-1:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [STATE_W-1:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        OP_WORD     = 2'd0,
        OP_FRACTION = 2'd1,
        OP_SEED     = 2'd2,
        OP_LOAD     = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_LCG_MULTIPLIER = 1'b0,
        CFG_LCG_INCREMENT  = 1'b1
    } cfg_reg_t;

    // Sequencer states of the core.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADVANCE,
        ST_MIX_A,
        ST_MIX_B,
        ST_FINISH
    } fsm_t;

    // Multiplier steps of one 64-bit product, from the low-by-low partial product to the last accumulation.
    typedef enum logic [1:0] {
        MS_LO_LO = 2'd0,
        MS_LO_HI = 2'd1,
        MS_HI_LO = 2'd2,
        MS_LAST  = 2'd3
    } mul_step_t;

    typedef struct packed {
        logic               start;
        logic [STATE_W-1:0] a;
        logic [STATE_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [STATE_W-1:0] product;
    } mul_rsp_t;

    // XSH-RR output permutation of a state value.
    function automatic logic [WORD_W-1:0] xsh_rr(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] x;
        logic [WORD_W-1:0]  w;
        logic [4:0]         rot;
        logic [2*WORD_W-1:0] dbl;
        x   = s ^ (s >> 18);
        w   = x[58:27];
        rot = s[63:59];
        dbl = {w, w} >> rot;
        return dbl[WORD_W-1:0];
    endfunction

    // SplitMix64 xor-shift step: the value folded with itself shifted right by sh.
    function automatic logic [STATE_W-1:0] xor_shift(input logic [STATE_W-1:0] v,
                                                     input logic [5:0] sh);
        return v ^ (v >> sh);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pcg32_if.sv
// Valid/ready channel interfaces for command and result items.
`default_nettype none

interface pcg32_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [63:0] operand;

    modport source (output valid, output op, output operand, input ready);
    modport sink   (input valid, input op, input operand, output ready);
endinterface

interface pcg32_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_word;
    logic [22:0] fraction;
    logic [63:0] state_now;

    modport source (output valid, output random_word, output fraction,
                    output state_now, input ready);
    modport sink   (input valid, input random_word, input fraction,
                    input state_now, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pcg32_mul.sv
// Iterative 64x64 multiplier (low 64 bits) built on one 32x32 multiplier.
`default_nettype none

module pcg32_mul (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pcg32_pkg::mul_req_t req,
    output pcg32_pkg::mul_rsp_t    rsp
);

    logic [pcg32_pkg::STATE_W-1:0] a_reg, a_next;
    logic [pcg32_pkg::STATE_W-1:0] b_reg, b_next;
    logic [pcg32_pkg::STATE_W-1:0] prod_reg, prod_next;
    logic [pcg32_pkg::STATE_W-1:0] acc_reg, acc_next;
    pcg32_pkg::mul_step_t          step_reg, step_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    logic [pcg32_pkg::HALF_W-1:0]  mul_x;
    logic [pcg32_pkg::HALF_W-1:0]  mul_y;
    logic [pcg32_pkg::HALF_W-1:0]  acc_hi_sum;

    // Operand selection for the shared 32x32 multiplier.
    always_comb
    begin
        unique case (step_reg)
            pcg32_pkg::MS_LO_LO:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[31:0];
            end
            pcg32_pkg::MS_LO_HI:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[63:32];
            end
            pcg32_pkg::MS_HI_LO:
            begin
                mul_x = a_reg[63:32];
                mul_y = b_reg[31:0];
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    // Cross products only reach the upper half of the result.
    assign acc_hi_sum = acc_reg[63:32] + prod_reg[31:0];

    // Step sequencing and accumulation.
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            step_next = pcg32_pkg::MS_LO_LO;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = mul_x * mul_y;
            unique case (step_reg)
                pcg32_pkg::MS_LO_LO:
                begin
                    step_next = pcg32_pkg::MS_LO_HI;
                end
                pcg32_pkg::MS_LO_HI:
                begin
                    acc_next  = prod_reg;
                    step_next = pcg32_pkg::MS_HI_LO;
                end
                pcg32_pkg::MS_HI_LO:
                begin
                    acc_next  = {acc_hi_sum, acc_reg[31:0]};
                    step_next = pcg32_pkg::MS_LAST;
                end
                pcg32_pkg::MS_LAST:
                begin
                    acc_next  = {acc_hi_sum, acc_reg[31:0]};
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= pcg32_pkg::MS_LO_LO;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operand and product registers carry no reset.
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pcg32_random_generator_core.sv
// PCG32 XSH-RR generator core: one command item in, one result item out.
// Each command item takes one of four operations and yields exactly one result item that
// reports the generator state after the operation. The state advance and the SplitMix64
// seeding run on one shared 32x32 multiplier, one 64-bit product at a time, and that sets
// the rate: a random word or fraction waits for one product, a seed for two dependent
// products and a state load for none, and no new item is taken before the last one has
// reached the output register. The result sits in that register, so the next item is
// taken while an earlier result still waits. Configuration writes belong to idle periods
// only.
`default_nettype none

module pcg32_random_generator_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    pcg32_cmd_if.sink        cmd,
    pcg32_res_if.source      res,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    pcg32_pkg::fsm_t               fsm_reg, fsm_next;
    pcg32_pkg::op_t                op_reg, op_next;
    logic [pcg32_pkg::STATE_W-1:0] gen_state_reg, gen_state_next;
    logic [pcg32_pkg::STATE_W-1:0] mult_reg, mult_next;
    logic [pcg32_pkg::STATE_W-1:0] incr_reg, incr_next;
    logic [pcg32_pkg::WORD_W-1:0]  word_reg, word_next;
    logic                          mul_start_reg, mul_start_next;
    logic [pcg32_pkg::STATE_W-1:0] mul_a_reg, mul_a_next;
    logic [pcg32_pkg::STATE_W-1:0] mul_b_reg, mul_b_next;
    logic                          out_valid_reg, out_valid_next;
    logic [pcg32_pkg::WORD_W-1:0]  out_word_reg, out_word_next;
    logic [pcg32_pkg::FRAC_W-1:0]  out_frac_reg, out_frac_next;
    logic [pcg32_pkg::STATE_W-1:0] out_state_reg, out_state_next;

    pcg32_pkg::mul_req_t           mul_req;
    pcg32_pkg::mul_rsp_t           mul_rsp;
    pcg32_pkg::op_t                cmd_op;
    logic                          cmd_accept;
    logic                          out_free;
    logic                          load_out;
    logic                          cmd_ready;
    logic [pcg32_pkg::STATE_W-1:0] seed_sum;
    logic [pcg32_pkg::STATE_W-1:0] seed_ctr;

    // Shared multiplier.
    assign mul_req.start = mul_start_reg;
    assign mul_req.a     = mul_a_reg;
    assign mul_req.b     = mul_b_reg;

    pcg32_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign cmd_op     = pcg32_pkg::op_t'(cmd.op);
    assign cmd_accept = cmd.valid && cmd_ready;
    assign out_free   = !out_valid_reg || res.ready;

    // A counter that lands on zero would mix to zero, so it steps once more.
    assign seed_sum = cmd.operand + pcg32_pkg::GOLDEN_GAMMA;
    assign seed_ctr = (seed_sum == '0) ? pcg32_pkg::GOLDEN_GAMMA : seed_sum;

    // Sequencer next state.
    always_comb
    begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            pcg32_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    unique case (cmd_op)
                        pcg32_pkg::OP_WORD,
                        pcg32_pkg::OP_FRACTION: fsm_next = pcg32_pkg::ST_ADVANCE;
                        pcg32_pkg::OP_SEED:     fsm_next = pcg32_pkg::ST_MIX_A;
                        pcg32_pkg::OP_LOAD:     fsm_next = pcg32_pkg::ST_FINISH;
                    endcase
                end
            end
            pcg32_pkg::ST_ADVANCE:
            begin
                if (mul_rsp.done)
                begin
                    fsm_next = pcg32_pkg::ST_FINISH;
                end
            end
            pcg32_pkg::ST_MIX_A:
            begin
                if (mul_rsp.done)
                begin
                    fsm_next = pcg32_pkg::ST_MIX_B;
                end
            end
            pcg32_pkg::ST_MIX_B:
            begin
                if (mul_rsp.done)
                begin
                    fsm_next = pcg32_pkg::ST_FINISH;
                end
            end
            pcg32_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    fsm_next = pcg32_pkg::ST_IDLE;
                end
            end
            default:
            begin
                fsm_next = pcg32_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        cmd_ready = 1'b0;
        load_out  = 1'b0;
        unique case (fsm_reg)
            pcg32_pkg::ST_IDLE:   cmd_ready = 1'b1;
            pcg32_pkg::ST_FINISH: load_out  = out_free;
            default:
            begin
                cmd_ready = 1'b0;
                load_out  = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        op_next        = op_reg;
        gen_state_next = gen_state_reg;
        mult_next      = mult_reg;
        incr_next      = incr_reg;
        word_next      = word_reg;
        mul_start_next = 1'b0;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        out_word_next  = out_word_reg;
        out_frac_next  = out_frac_reg;
        out_state_next = out_state_reg;

        // Configuration writes.
        if (cfg_we)
        begin
            unique case (pcg32_pkg::cfg_reg_t'(cfg_index))
                pcg32_pkg::CFG_LCG_MULTIPLIER: mult_next = cfg_data;
                pcg32_pkg::CFG_LCG_INCREMENT:  incr_next = cfg_data;
            endcase
        end

        unique case (fsm_reg)
            pcg32_pkg::ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    op_next = cmd_op;
                    unique case (cmd_op)
                        pcg32_pkg::OP_WORD,
                        pcg32_pkg::OP_FRACTION:
                        begin
                            word_next      = pcg32_pkg::xsh_rr(gen_state_reg);
                            mul_a_next     = gen_state_reg;
                            mul_b_next     = mult_reg;
                            mul_start_next = 1'b1;
                        end
                        pcg32_pkg::OP_SEED:
                        begin
                            mul_a_next     = pcg32_pkg::xor_shift(seed_ctr, 6'd30);
                            mul_b_next     = pcg32_pkg::MIX_MUL_A;
                            mul_start_next = 1'b1;
                        end
                        pcg32_pkg::OP_LOAD:
                        begin
                            gen_state_next = cmd.operand;
                        end
                    endcase
                end
            end
            pcg32_pkg::ST_ADVANCE:
            begin
                if (mul_rsp.done)
                begin
                    gen_state_next = mul_rsp.product + incr_reg;
                end
            end
            pcg32_pkg::ST_MIX_A:
            begin
                if (mul_rsp.done)
                begin
                    mul_a_next     = pcg32_pkg::xor_shift(mul_rsp.product, 6'd27);
                    mul_b_next     = pcg32_pkg::MIX_MUL_B;
                    mul_start_next = 1'b1;
                end
            end
            pcg32_pkg::ST_MIX_B:
            begin
                if (mul_rsp.done)
                begin
                    gen_state_next = pcg32_pkg::xor_shift(mul_rsp.product, 6'd31);
                end
            end
            pcg32_pkg::ST_FINISH:
            begin
                if (load_out)
                begin
                    out_state_next = gen_state_reg;
                    out_word_next  = '0;
                    out_frac_next  = '0;
                    if (op_reg == pcg32_pkg::OP_WORD)
                    begin
                        out_word_next = word_reg;
                    end
                    else if (op_reg == pcg32_pkg::OP_FRACTION)
                    begin
                        out_word_next = word_reg;
                        out_frac_next = word_reg[pcg32_pkg::FRAC_W-1:0];
                    end
                end
            end
            default:
            begin
                mul_start_next = 1'b0;
            end
        endcase
    end

    // Result slot occupancy.
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= pcg32_pkg::ST_IDLE;
            gen_state_reg <= pcg32_pkg::STATE_RESET;
            mult_reg      <= pcg32_pkg::MULT_RESET;
            incr_reg      <= pcg32_pkg::INCR_RESET;
            mul_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            gen_state_reg <= gen_state_next;
            mult_reg      <= mult_next;
            incr_reg      <= incr_next;
            mul_start_reg <= mul_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        word_reg      <= word_next;
        mul_a_reg     <= mul_a_next;
        mul_b_reg     <= mul_b_next;
        out_word_reg  <= out_word_next;
        out_frac_reg  <= out_frac_next;
        out_state_reg <= out_state_next;
    end

    assign cmd.ready       = cmd_ready;
    assign res.valid       = out_valid_reg;
    assign res.random_word = out_word_reg;
    assign res.fraction    = out_frac_reg;
    assign res.state_now   = out_state_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pcg32_checker.sv
// Port-level checker for the PCG32 generator core, bound to the top level.
`default_nettype none

`include "pcg32_random_generator_core_defines.svh"

module pcg32_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cmd_valid,
    input wire logic        cmd_ready,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [31:0] random_word,
    input wire logic [22:0] fraction,
    input wire logic [63:0] state_now
);

    // A stalled result keeps its payload.
    `PCG32_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(random_word) && $stable(fraction) && $stable(state_now))

    // The core works on one item at a time.
    `PCG32_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready)

    // A fraction is either zero or the low bits of its word.
    `PCG32_ASSERT_NOW(a_frac_from_word, res_valid, fraction == 23'd0 || fraction == random_word[22:0])

    // A zero word never comes with a nonzero fraction.
    `PCG32_ASSERT_NOW(a_zero_word_frac, res_valid && random_word == 32'd0, fraction == 23'd0)

endmodule

bind pcg32_random_generator_core pcg32_checker u_pcg32_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .random_word (res.random_word),
    .fraction    (res.fraction),
    .state_now   (res.state_now)
);

`default_nettype wire

FILE: sim/tb_pcg32_random_generator_core.sv
// Self-checking testbench for the PCG32 XSH-RR generator core with its own predictor.
`default_nettype none

module tb_pcg32_random_generator_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 400_000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int PHASE_ITEMS     = 190;
    localparam int LONG_HOLD_AT    = 400;
    localparam int LONG_HOLD_LEN   = 300;
    localparam int MAX_PRINTED     = 50;

    typedef struct {
        pcg32_pkg::op_t op;
        logic [63:0]    operand;
    } pcg_cmd_t;

    typedef struct {
        logic [31:0] word;
        logic [22:0] frac;
        logic [63:0] state;
    } pcg_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_data;

    pcg32_cmd_if cmd_ch ();
    pcg32_res_if res_ch ();

    pcg32_random_generator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Generator state and LCG constants as the predictor sees them.
    logic [63:0] model_state = pcg32_pkg::STATE_RESET;
    logic [63:0] model_mult  = pcg32_pkg::MULT_RESET;
    logic [63:0] model_incr  = pcg32_pkg::INCR_RESET;

    pcg_cmd_t    pending_cmds[$];
    pcg_result_t expected_results[$];
    pcg_cmd_t    taken_cmd;
    pcg_result_t want;

    int error_count  = 0;
    int cycle_count  = 0;
    int items_taken  = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int hold_left    = 0;
    int mode_left    = 0;
    int stall_mode   = 0;
    bit long_hold_done = 1'b0;

    // One SplitMix64 finalizer round.
    function automatic logic [63:0] splitmix64(logic [63:0] c);
        logic [63:0] t;
        t = c;
        t = (t ^ (t >> 30)) * pcg32_pkg::MIX_MUL_A;
        t = (t ^ (t >> 27)) * pcg32_pkg::MIX_MUL_B;
        return t ^ (t >> 31);
    endfunction

    // Computes the result of one command item and moves the generator state on.
    function automatic pcg_result_t pcg_predict(pcg_cmd_t c);
        pcg_result_t r;
        logic [63:0] old;
        logic [63:0] ctr;
        logic [63:0] mixed;
        logic [31:0] xs;
        int          rot;
        r.word = '0;
        r.frac = '0;
        case (c.op)
            pcg32_pkg::OP_WORD, pcg32_pkg::OP_FRACTION:
            begin
                old = model_state;
                xs  = 32'((old ^ (old >> 18)) >> 27);
                rot = int'(old[63:59]);
                r.word = (xs >> rot) | (xs << (32 - rot));
                model_state = old * model_mult + model_incr;
                if (c.op == pcg32_pkg::OP_FRACTION)
                begin
                    r.frac = r.word[22:0];
                end
            end
            pcg32_pkg::OP_SEED:
            begin
                ctr   = c.operand + pcg32_pkg::GOLDEN_GAMMA;
                mixed = splitmix64(ctr);
                // A zero mix only comes from a zero counter; one more gamma step fixes it.
                if (mixed == 64'd0)
                begin
                    ctr   = ctr + pcg32_pkg::GOLDEN_GAMMA;
                    mixed = splitmix64(ctr);
                end
                model_state = mixed;
            end
            default:
            begin
                model_state = c.operand;
            end
        endcase
        r.state = model_state;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
        if (error_count < MAX_PRINTED)
        begin
            $display("mismatch %s: got %h, expected %h, cycle %0d",
                     what, got, exp_val, cycle_count);
        end
        error_count++;
    endtask

    task automatic add_cmd(pcg32_pkg::op_t op, logic [63:0] operand);
        pcg_cmd_t c;
        c.op      = op;
        c.operand = operand;
        pending_cmds.push_back(c);
    endtask

    // Mostly runs of words and fractions between seeds and loads, with extreme operands.
    task automatic add_random_items(int n);
        int             pick;
        pcg32_pkg::op_t op;
        logic [63:0]    operand;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                op = pcg32_pkg::OP_WORD;
            else if (pick < 75)
                op = pcg32_pkg::OP_FRACTION;
            else if (pick < 90)
                op = pcg32_pkg::OP_SEED;
            else
                op = pcg32_pkg::OP_LOAD;
            case ($urandom_range(0, 11))
                0:       operand = 64'd0;
                1:       operand = '1;
                2:       operand = 64'd0 - pcg32_pkg::GOLDEN_GAMMA;
                default: operand = {$urandom, $urandom};
            endcase
            add_cmd(op, operand);
        end
    endtask

    // Waits until every item was taken and answered, then lets the core settle.
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || expected_results.size() != 0 || cmd_ch.valid)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(pcg32_pkg::cfg_reg_t idx, logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == pcg32_pkg::CFG_LCG_MULTIPLIER)
            model_mult = value;
        else
            model_incr = value;
    endtask

    task automatic run_phase(logic [63:0] mult, logic [63:0] incr);
        write_config(pcg32_pkg::CFG_LCG_MULTIPLIER, mult);
        write_config(pcg32_pkg::CFG_LCG_INCREMENT, incr);
        @(negedge clk);
        add_random_items(PHASE_ITEMS);
        wait_idle();
    endtask

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run timeout.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Command driver: offers queued items in bursts separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid   <= 1'b0;
            cmd_ch.op      <= pcg32_pkg::OP_WORD;
            cmd_ch.operand <= '0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                taken_cmd = pending_cmds.pop_front();
                expected_results.push_back(pcg_predict(taken_cmd));
                items_taken <= items_taken + 1;
                burst_left = burst_left - 1;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
                end
            end
            // An item on offer stays put until the core takes it.
            if (!(cmd_ch.valid && !cmd_ch.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    cmd_ch.valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    cmd_ch.valid   <= 1'b1;
                    cmd_ch.op      <= pending_cmds[0].op;
                    cmd_ch.operand <= pending_cmds[0].operand;
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result back-pressure: random stall modes, plus one long hold so the core fills up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else if (!long_hold_done && items_taken >= LONG_HOLD_AT)
        begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD_LEN;
            res_ch.ready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     = hold_left - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(16, 96);
            end
            else
            begin
                mode_left = mode_left - 1;
            end
            case (stall_mode)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                default: res_ch.ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    // Result monitor: compares each taken result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing expected", res_ch.state_now, 64'd0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_ch.random_word !== want.word)
                    report_mismatch("random_word", 64'(res_ch.random_word), 64'(want.word));
                if (res_ch.fraction !== want.frac)
                    report_mismatch("fraction", 64'(res_ch.fraction), 64'(want.frac));
                if (res_ch.state_now !== want.state)
                    report_mismatch("state_now", res_ch.state_now, want.state);
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = pcg32_pkg::CFG_LCG_MULTIPLIER;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed items from the reset state and its default constants.
        add_cmd(pcg32_pkg::OP_WORD, 64'd0);
        add_cmd(pcg32_pkg::OP_FRACTION, '1);
        add_cmd(pcg32_pkg::OP_LOAD, 64'd0);
        add_cmd(pcg32_pkg::OP_WORD, 64'd0);
        add_cmd(pcg32_pkg::OP_FRACTION, 64'd0);
        add_cmd(pcg32_pkg::OP_LOAD, '1);
        add_cmd(pcg32_pkg::OP_WORD, 64'd0);
        // This state gives an all-ones word with no rotation, so the fraction is at its top.
        add_cmd(pcg32_pkg::OP_LOAD, 64'h07FF_FE00_0000_0000);
        add_cmd(pcg32_pkg::OP_FRACTION, 64'd0);
        add_cmd(pcg32_pkg::OP_LOAD, 64'hF800_0000_0000_0000);
        add_cmd(pcg32_pkg::OP_WORD, 64'd0);
        add_cmd(pcg32_pkg::OP_LOAD, 64'h8000_0000_0000_0001);
        add_cmd(pcg32_pkg::OP_FRACTION, 64'd0);
        add_cmd(pcg32_pkg::OP_SEED, 64'd0);
        add_cmd(pcg32_pkg::OP_WORD, 64'd0);
        add_cmd(pcg32_pkg::OP_SEED, '1);
        // Seed whose counter wraps to zero and needs the second mixing round.
        add_cmd(pcg32_pkg::OP_SEED, 64'd0 - pcg32_pkg::GOLDEN_GAMMA);
        add_cmd(pcg32_pkg::OP_FRACTION, 64'd0);
        add_cmd(pcg32_pkg::OP_SEED, 64'h5555_5555_5555_5555);
        add_cmd(pcg32_pkg::OP_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
        add_cmd(pcg32_pkg::OP_WORD, 64'd0);
        add_cmd(pcg32_pkg::OP_FRACTION, 64'd0);
        add_random_items(PHASE_ITEMS);
        wait_idle();

        // Random phases under several LCG settings, extremes included.
        run_phase(64'd0, 64'd0);
        run_phase('1, '1);
        run_phase(64'd1, {$urandom, $urandom});
        run_phase({$urandom, $urandom}, {$urandom, $urandom});
        run_phase(pcg32_pkg::MULT_RESET, pcg32_pkg::INCR_RESET);

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
